### rtl/lfu_pkg.sv
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared widths, action codes and the control/status bundles of the
// least-frequently-used slot replacement unit.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int KEY_ID_W   = 8;
  localparam int SLOT_IDX_W = 4;
  localparam int ACTION_W   = 2;
  localparam int EVICT_W    = 8;
  localparam int COUNT_W    = 16;
  localparam int CFG_W      = 5;

  localparam logic [CFG_W-1:0]   SLOTS_RESET = 5'd16;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = 16'hFFFF;

  typedef logic [ACTION_W-1:0] action_t;

  localparam action_t ACT_HIT     = 2'd0;
  localparam action_t ACT_FILL    = 2'd1;
  localparam action_t ACT_REPLACE = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic scan;
    logic commit;
  } lfu_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic key_valid;
    logic scan_done;
    logic out_free;
  } lfu_status_t;

endpackage

### rtl/lfu_ifs.sv
// ----------------------------------------------------------------------------
// lfu channel interfaces
// Valid/ready channels for keys, results and the slot count register.
// ----------------------------------------------------------------------------
interface lfu_req_if;
  import lfu_pkg::*;
  logic                valid;
  logic                ready;
  logic [KEY_ID_W-1:0] key_id;
  modport source (output valid, output key_id, input ready);
  modport sink   (input valid, input key_id, output ready);
endinterface

interface lfu_rsp_if;
  import lfu_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [SLOT_IDX_W-1:0] slot_index;
  action_t               action;
  logic [EVICT_W-1:0]    evicted_key;
  logic [COUNT_W-1:0]    use_count;
  modport source (output valid, output slot_index, output action, output evicted_key,
                  output use_count, input ready);
  modport sink   (input valid, input slot_index, input action, input evicted_key,
                  input use_count, output ready);
endinterface

interface lfu_cfg_if;
  import lfu_pkg::*;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] slots_in_use;
  modport source (output valid, output slots_in_use, input ready);
  modport sink   (input valid, input slots_in_use, output ready);
endinterface

### rtl/lfu_ctrl.sv
// ----------------------------------------------------------------------------
// lfu_ctrl
// Sequencer: accept a key, scan the slots one per cycle, then commit the
// update and the result word.
// ----------------------------------------------------------------------------
module lfu_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  lfu_pkg::lfu_status_t status,
  output lfu_pkg::lfu_cmd_t    cmd
);
  import lfu_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        // key zero is taken and dropped
        if (in_valid && status.key_valid) begin
          cmd.start  = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_done) begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/lfu_dpath.sv
// ----------------------------------------------------------------------------
// lfu_dpath
// Slot storage, scan pointer, running victim search, rank bookkeeping and
// the result register.
// ----------------------------------------------------------------------------
module lfu_dpath #(
  parameter int MAX_SLOTS = 16,
  parameter int KEY_BITS  = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  lfu_pkg::lfu_cmd_t                 cmd,
  output lfu_pkg::lfu_status_t              status,
  input  logic [lfu_pkg::KEY_ID_W-1:0]      key_id,
  input  logic                              cfg_valid,
  input  logic [lfu_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [lfu_pkg::SLOT_IDX_W-1:0]    out_slot_index,
  output lfu_pkg::action_t                  out_action,
  output logic [lfu_pkg::EVICT_W-1:0]       out_evicted_key,
  output logic [lfu_pkg::COUNT_W-1:0]       out_use_count
);
  import lfu_pkg::*;

  localparam int IDX_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int FILL_W = $clog2(MAX_SLOTS + 1);

  logic [KEY_BITS-1:0] slot_key   [MAX_SLOTS];
  logic [COUNT_W-1:0]  slot_count [MAX_SLOTS];
  logic [IDX_W-1:0]    slot_rank  [MAX_SLOTS];
  logic [FILL_W-1:0]   filled;
  logic [CFG_W-1:0]    slots_in_use;

  logic [KEY_BITS-1:0] key_in;
  logic [KEY_BITS-1:0] cur_key;
  logic [IDX_W-1:0]    scan_idx;
  logic [IDX_W-1:0]    best_idx;
  logic [COUNT_W-1:0]  best_count;
  logic [IDX_W-1:0]    best_rank;
  logic [KEY_BITS-1:0] best_key;

  logic [IDX_W-1:0]    tgt;
  action_t             act;
  logic [COUNT_W-1:0]  new_count;
  logic [KEY_BITS-1:0] evict_key;
  logic [IDX_W-1:0]    evict_rank;

  logic [7:0]          cfg_wide;
  logic [7:0]          last_wide;
  logic [IDX_W-1:0]    last_idx;
  logic [KEY_BITS-1:0] rd_key;
  logic [COUNT_W-1:0]  rd_count;
  logic [IDX_W-1:0]    rd_rank;
  logic                is_empty;
  logic                is_match;
  logic                take_cur;
  logic [IDX_W-1:0]    nb_idx;
  logic [COUNT_W-1:0]  nb_count;
  logic [IDX_W-1:0]    nb_rank;
  logic [KEY_BITS-1:0] nb_key;
  logic [COUNT_W-1:0]  sat_count;
  logic [FILL_W-1:0]   filled_m1;
  logic                out_free;

  assign key_in = KEY_BITS'(key_id);

  // last visible slot: zero counts as one, clamp at the array size
  assign cfg_wide = 8'(slots_in_use);
  always_comb begin
    if (cfg_wide == 8'd0) begin
      last_wide = 8'd0;
    end else if (cfg_wide > 8'(MAX_SLOTS)) begin
      last_wide = 8'(MAX_SLOTS - 1);
    end else begin
      last_wide = cfg_wide - 8'd1;
    end
  end
  assign last_idx = last_wide[IDX_W-1:0];

  assign rd_key   = slot_key[scan_idx];
  assign rd_count = slot_count[scan_idx];
  assign rd_rank  = slot_rank[scan_idx];
  assign is_empty = (rd_key == '0);
  assign is_match = (rd_key == cur_key);

  // lowest count wins, oldest insertion breaks a tie; slot 0 seeds the search
  assign take_cur = (scan_idx == '0) || (rd_count < best_count) ||
                    ((rd_count == best_count) && (rd_rank < best_rank));
  assign nb_idx   = take_cur ? scan_idx : best_idx;
  assign nb_count = take_cur ? rd_count : best_count;
  assign nb_rank  = take_cur ? rd_rank  : best_rank;
  assign nb_key   = take_cur ? rd_key   : best_key;

  assign sat_count = (rd_count == COUNT_MAX) ? rd_count : rd_count + COUNT_W'(1);
  assign filled_m1 = filled - FILL_W'(1);

  assign out_free = !out_valid || out_ready;

  assign status.key_valid = (key_in != '0);
  assign status.scan_done = is_empty || is_match || (scan_idx == last_idx);
  assign status.out_free  = out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= SLOTS_RESET;
    end else if (cfg_valid) begin
      slots_in_use <= cfg_data;
    end
  end

  // scan state
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cur_key  <= key_in;
      scan_idx <= '0;
    end
    if (cmd.scan) begin
      scan_idx   <= scan_idx + IDX_W'(1);
      best_idx   <= nb_idx;
      best_count <= nb_count;
      best_rank  <= nb_rank;
      best_key   <= nb_key;
      if (is_empty || is_match) begin
        tgt       <= scan_idx;
        act       <= is_empty ? ACT_FILL : ACT_HIT;
        new_count <= is_empty ? COUNT_W'(1) : sat_count;
        evict_key <= '0;
      end else if (scan_idx == last_idx) begin
        tgt        <= nb_idx;
        act        <= ACT_REPLACE;
        new_count  <= COUNT_W'(1);
        evict_key  <= nb_key;
        evict_rank <= nb_rank;
      end
    end
  end

  // slot keys and fill count; a zero key marks an empty slot
  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
      for (int i = 0; i < MAX_SLOTS; i++) begin
        slot_key[i] <= '0;
      end
    end else if (cmd.commit) begin
      slot_key[tgt] <= cur_key;
      if (act == ACT_FILL && filled < FILL_W'(MAX_SLOTS)) begin
        filled <= filled + FILL_W'(1);
      end
    end
  end

  // counts and dense age ranks
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      slot_count[tgt] <= new_count;
      if (act == ACT_REPLACE) begin
        // close the gap left by the victim, across all occupied slots
        for (int i = 0; i < MAX_SLOTS; i++) begin
          if (slot_key[i] != '0 && slot_rank[i] > evict_rank) begin
            slot_rank[i] <= slot_rank[i] - IDX_W'(1);
          end
        end
        slot_rank[tgt] <= filled_m1[IDX_W-1:0];
      end else if (act == ACT_FILL) begin
        slot_rank[tgt] <= filled[IDX_W-1:0];
      end
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_slot_index  <= SLOT_IDX_W'(tgt);
      out_action      <= act;
      out_evicted_key <= EVICT_W'(evict_key);
      out_use_count   <= new_count;
    end
  end

`ifndef NO_ASSERTIONS
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> out_free)
    else $error("commit while result word still held");

  a_word_after_commit: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("no result word after commit");

  a_fill_grows: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && act == ACT_FILL) |=> filled == $past(filled) + FILL_W'(1))
    else $error("fill count did not advance on a fill");

  a_evict_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_action != ACT_REPLACE) |-> out_evicted_key == '0)
    else $error("evicted key set without a replacement");

  a_new_count_one: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_action != ACT_HIT) |-> out_use_count == COUNT_W'(1))
    else $error("new key does not start at count one");
`endif

endmodule

### rtl/lfu_slot_replacement_unit.sv
// ----------------------------------------------------------------------------
// lfu_slot_replacement_unit
// Least-frequently-used slot replacement with oldest-first tie break.
//
//   channel  dir  word
//   req      in   key_id
//   rsp      out  slot_index, action, evicted_key, use_count
//   cfg      in   slots_in_use (always ready)
//
// A key is taken, then the slots are scanned (at most the visible slot count),
// then the update and the result word are committed; the single slot read port
// walks one slot per cycle. Key zero is taken with no word.
// The result register frees the unit once its word is loaded; a stalled rsp
// holds the next key in its commit cycle. Reset empties all slots at once.
// ----------------------------------------------------------------------------
module lfu_slot_replacement_unit #(
  parameter int MAX_SLOTS = 16,
  parameter int KEY_BITS  = 8
) (
  input  logic       clk,
  input  logic       rst,
  lfu_req_if.sink    req,
  lfu_rsp_if.source  rsp,
  lfu_cfg_if.sink    cfg
);
  import lfu_pkg::*;

  lfu_cmd_t    cmd;
  lfu_status_t status;

  assign cfg.ready = 1'b1;

  lfu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .status   (status),
    .cmd      (cmd)
  );

  lfu_dpath #(
    .MAX_SLOTS (MAX_SLOTS),
    .KEY_BITS  (KEY_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .key_id          (req.key_id),
    .cfg_valid       (cfg.valid),
    .cfg_data        (cfg.slots_in_use),
    .out_ready       (rsp.ready),
    .out_valid       (rsp.valid),
    .out_slot_index  (rsp.slot_index),
    .out_action      (rsp.action),
    .out_evicted_key (rsp.evicted_key),
    .out_use_count   (rsp.use_count)
  );

endmodule
